@@ rtl/core/lmcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmcr_pkg
// DES tables, round helpers and LM key preparation for the LM response core.
// ----------------------------------------------------------------------------
package lmcr_pkg;

    typedef struct packed {
        logic [27:0] c;
        logic [27:0] d;
        logic [31:0] l;
        logic [31:0] r;
    } t_des;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CHALLENGE = 2'd0;
    localparam t_cfg_idx CFG_TARGET_1  = 2'd1;
    localparam t_cfg_idx CFG_TARGET_2  = 2'd2;
    localparam t_cfg_idx CFG_TARGET_3  = 2'd3;

    localparam logic [63:0] MAGIC_BLOCK = 64'h4B47532140232425;

    localparam int TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam int TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam int TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam int TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam int TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam int TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    localparam int TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TAB_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] o;
        for (int i = 0; i < 64; i++) o[63-i] = v[64-TAB_IP[i]];
        return o;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] o;
        for (int i = 0; i < 64; i++) o[63-i] = v[64-TAB_FP[i]];
        return o;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] o;
        for (int i = 0; i < 56; i++) o[55-i] = v[64-TAB_PC1[i]];
        return o;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] o;
        for (int i = 0; i < 48; i++) o[47-i] = v[56-TAB_PC2[i]];
        return o;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] o;
        logic [5:0]  b;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
        x = x ^ sub;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) o[31-i] = s[32-TAB_P[i]];
        return o;
    endfunction

    // One DES round, key schedule carried along with the data.
    function automatic t_des des_round(input t_des st, input int rnd);
        t_des o;
        if (TAB_ROT[rnd] == 1) begin
            o.c = {st.c[26:0], st.c[27]};
            o.d = {st.d[26:0], st.d[27]};
        end else begin
            o.c = {st.c[25:0], st.c[27:26]};
            o.d = {st.d[25:0], st.d[27:26]};
        end
        o.l = st.r;
        o.r = st.l ^ feistel(st.r, perm_pc2({o.c, o.d}));
        return o;
    endfunction

    function automatic t_des des_load(input logic [63:0] block, input logic [55:0] k56);
        t_des        o;
        logic [63:0] k;
        logic [63:0] t;
        logic [55:0] cd;
        for (int i = 0; i < 8; i++) k[63-8*i -: 8] = {k56[55-7*i -: 7], 1'b0};
        cd  = perm_pc1(k);
        t   = perm_ip(block);
        o.c = cd[55:28];
        o.d = cd[27:0];
        o.l = t[63:32];
        o.r = t[31:0];
        return o;
    endfunction

    function automatic logic [63:0] des_final(input t_des st);
        return perm_fp({st.r, st.l});
    endfunction

    function automatic logic [55:0] upcase7(input logic [55:0] v);
        logic [55:0] o;
        logic [7:0]  b;
        for (int i = 0; i < 7; i++) begin
            b = v[55-8*i -: 8];
            if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
            o[55-8*i -: 8] = b;
        end
        return o;
    endfunction

endpackage

@@ rtl/core/lm_challenge_response.sv @@
// ----------------------------------------------------------------------------
// lm_challenge_response
// LM hash of a 14-byte password and the 24-byte challenge response, compared
// with a configured target. Fully pipelined, one DES round per stage.
// ----------------------------------------------------------------------------
//  channel | direction | transfer holds
//  s_*     | in        | tdata[55:0] pass_front, [111:56] pass_back
//  m_*     | out       | hashes, three response blocks, match flag
//  cfg_*   | in        | register index (0..3) and 64-bit value
//
//  Stages in order: prep stage, 16 hash rounds, key stage, 16 response
//  rounds, final/compare stage. Throughput: one item per cycle unless
//  m_tready stalls the output; set by the one-round-per-stage DES chain.
//  Reset clears all valid bits and the configuration registers.
//  A stall on m_tready freezes the whole pipeline; s_tready drops only while
//  the output register holds an untaken result.
// ----------------------------------------------------------------------------
module lm_challenge_response
    import lmcr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,    // pass_front[55:0], pass_back[111:56]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [327:0] m_tdata,    // hash_front, hash_back, resp_first,
                                     // resp_second, resp_third (64 each), match
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    logic        w_adv;
    logic [63:0] r_challenge, r_tgt1, r_tgt2, r_tgt3;

    // Hash chain: stage 0 is the loaded state, stage k after round k.
    logic        r_vh [17];
    t_des        r_h  [17][2];
    // Response chain.
    logic        r_vq [17];
    t_des        r_q  [17][3];
    logic [63:0] r_qhf [17];
    logic [63:0] r_qhb [17];

    logic         r_o_valid;
    logic [327:0] r_o_data;

    logic [63:0] w_hf, w_hb, w_r1, w_r2, w_r3;

    // Advance everything whenever the output can take a new item.
    assign w_adv       = !r_o_valid || m_tready;
    assign s_tready    = w_adv;
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_o_valid;
    assign m_tdata     = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_challenge <= '0;
            r_tgt1      <= '0;
            r_tgt2      <= '0;
            r_tgt3      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHALLENGE: r_challenge <= i_cfg_data;
                CFG_TARGET_1:  r_tgt1      <= i_cfg_data;
                CFG_TARGET_2:  r_tgt2      <= i_cfg_data;
                CFG_TARGET_3:  r_tgt3      <= i_cfg_data;
                default:       r_tgt3      <= r_tgt3;
            endcase
        end
    end

    // Prep: upper-case, spread keys, PC1 and IP of the magic block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh[0] <= 1'b0;
        end else if (w_adv) begin
            r_vh[0] <= s_tvalid;
        end
        if (w_adv) begin
            r_h[0][0] <= des_load(MAGIC_BLOCK, upcase7(s_tdata[55:0]));
            r_h[0][1] <= des_load(MAGIC_BLOCK, upcase7(s_tdata[111:56]));
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_hash
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vh[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_vh[g+1] <= r_vh[g];
            end
            if (w_adv) begin
                r_h[g+1][0] <= des_round(r_h[g][0], g);
                r_h[g+1][1] <= des_round(r_h[g][1], g);
            end
        end
    end

    // Key stage: finish the hash, build the three response keys.
    assign w_hf = des_final(r_h[16][0]);
    assign w_hb = des_final(r_h[16][1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq[0] <= 1'b0;
        end else if (w_adv) begin
            r_vq[0] <= r_vh[16];
        end
        if (w_adv) begin
            r_q[0][0] <= des_load(r_challenge, w_hf[63:8]);
            r_q[0][1] <= des_load(r_challenge, {w_hf[7:0], w_hb[63:16]});
            r_q[0][2] <= des_load(r_challenge, {w_hb[15:0], 40'd0});
            r_qhf[0]  <= w_hf;
            r_qhb[0]  <= w_hb;
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_resp
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vq[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_vq[g+1] <= r_vq[g];
            end
            if (w_adv) begin
                for (int k = 0; k < 3; k++) r_q[g+1][k] <= des_round(r_q[g][k], g);
                r_qhf[g+1] <= r_qhf[g];
                r_qhb[g+1] <= r_qhb[g];
            end
        end
    end

    // Final permutation and target compare into the output register.
    assign w_r1 = des_final(r_q[16][0]);
    assign w_r2 = des_final(r_q[16][1]);
    assign w_r3 = des_final(r_q[16][2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_vq[16];
        end
        if (w_adv) begin
            r_o_data <= {7'd0,
                         (w_r1 == r_tgt1) && (w_r2 == r_tgt2) && (w_r3 == r_tgt3),
                         w_r3, w_r2, w_r1, r_qhb[16], r_qhf[16]};
        end
    end

endmodule

@@ rtl/core/lmcr_checker.sv @@
// ----------------------------------------------------------------------------
// lmcr_checker
// Port-level checks for lm_challenge_response, attached by bind.
// ----------------------------------------------------------------------------
module lmcr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // Hold a result until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    // Input side stalls exactly when the output holds an untaken result.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lm_challenge_response lmcr_checker u_lmcr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
